>>> rtl/tsta_pkg.sv
// Shared types, codes and gap test for the time slot table allocator.
package tsta_pkg;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_AUTO   = 2'd1;
    localparam logic [1:0] FUNC_FIND   = 2'd2;
    localparam logic [1:0] FUNC_CLEAR  = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_ID    = 3'd1;
    localparam logic [2:0] ST_CONFLICT  = 3'd2;
    localparam logic [2:0] ST_NO_WINDOW = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_FIND_RD,
        S_FIND_EV,
        S_FIND_END,
        S_INS_INIT,
        S_INS_RD,
        S_INS_EV,
        S_INS_DEC,
        S_SHF_RD,
        S_SHF_WR,
        S_INS_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic        completion;
        logic [31:0] divider_offset;
        logic [31:0] period_divider;
        logic [15:0] arg_handle;
        logic [31:0] owner_id;
        logic [31:0] slot_length;
        logic [31:0] slot_start;
    } t_entry;

    // Gap [lo, hi) clipped to [after, upper], tested against len.
    function automatic logic gap_fits(input logic [32:0] lo, input logic [32:0] hi,
                                      input logic [32:0] after, input logic [32:0] upper,
                                      input logic [32:0] len);
        logic [32:0] l;
        logic [32:0] h;
        l = (after > lo) ? after : lo;
        h = (upper < hi) ? upper : hi;
        return (l < h) && ((h - l) >= len);
    endfunction

    function automatic logic [32:0] gap_lo(input logic [32:0] lo, input logic [32:0] after);
        return (after > lo) ? after : lo;
    endfunction

endpackage

>>> rtl/tsta_ram.sv
// Generic single write, single registered read port RAM.
module tsta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/time_slot_table_allocator_top.sv
// Time slot table allocator: sorted slot table with insert, auto allocate, find and clear.
// One operation per beat; the block is not ready while one is in progress. The table sits
// in a single-port-read RAM, so every entry visit is a read step and an evaluate step.
// Find visits the entries in order until a gap fits, else tests the gap after the last;
// insert scans the entries for overlap, then shifts those above the insert position up
// by one and writes the new entry; auto allocate is a find followed by an insert. A result
// is held in an output register, so the next beat is taken while it waits.
module time_slot_table_allocator_top #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // component_id, function_id, arg_handle, slot_start, slot_length, after_time,
    // before_time, period_divider, divider_offset, completion, zero pad
    input  logic [247:0] s_axis_tdata,
    // func
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status, window_start, entry_count, zero pad
    output logic [47:0]  m_axis_tdata
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = $bits(tsta_pkg::t_entry);

    tsta_pkg::t_state r_state, n_state;

    logic [31:0]   r_cycle;
    logic [1:0]    r_func;
    logic [15:0]   r_comp_id, r_func_id, r_arg;
    logic [31:0]   r_start, r_len, r_after, r_before, r_div, r_off;
    logic          r_done_flag;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_pos, n_pos;
    logic [32:0]   r_prev_end, n_prev_end;
    logic [31:0]   n_start;
    logic [2:0]    r_status, n_status;
    logic [31:0]   r_win, n_win;
    logic          r_out_valid;
    logic [47:0]   r_out_data;

    logic          accept;
    logic          ids_ok;
    logic          last_entry;
    logic [32:0]   cyc33, len33, start33, new_end, ent_end;
    tsta_pkg::t_entry rd_ent, new_ent, wr_ent;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_rdata;
    logic          gap_ok, end_ok;

    assign s_axis_tready = (r_state == tsta_pkg::S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign ids_ok        = (r_comp_id != 16'd0) && (r_func_id != 16'd0);
    assign last_entry    = (CW'(r_idx + CW'(1)) == r_count);

    assign cyc33   = {1'b0, r_cycle};
    assign len33   = {1'b0, r_len};
    assign start33 = {1'b0, r_start};
    assign new_end = start33 + len33;
    assign rd_ent  = tsta_pkg::t_entry'(ram_rdata);
    assign ent_end = {1'b0, rd_ent.slot_start} + {1'b0, rd_ent.slot_length};

    assign gap_ok = tsta_pkg::gap_fits(r_prev_end, {1'b0, rd_ent.slot_start},
                                       {1'b0, r_after}, {1'b0, r_before}, len33);
    assign end_ok = tsta_pkg::gap_fits(r_prev_end, cyc33,
                                       {1'b0, r_after}, {1'b0, r_before}, len33);

    always_comb begin
        new_ent.completion     = r_done_flag;
        new_ent.divider_offset = r_off;
        new_ent.period_divider = r_div;
        new_ent.arg_handle     = r_arg;
        new_ent.owner_id       = {r_comp_id, r_func_id};
        new_ent.slot_length    = r_len;
        new_ent.slot_start     = r_start;
    end

    assign ram_we    = (r_state == tsta_pkg::S_SHF_WR) || (r_state == tsta_pkg::S_INS_WR);
    assign ram_waddr = (r_state == tsta_pkg::S_SHF_WR) ? AW'(r_idx + CW'(1)) : r_pos[AW-1:0];
    assign wr_ent    = (r_state == tsta_pkg::S_SHF_WR) ? rd_ent : new_ent;
    assign ram_raddr = r_idx[AW-1:0];

    tsta_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_ent),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tsta_pkg::S_IDLE: begin
                if (accept) n_state = tsta_pkg::S_DISPATCH;
            end
            tsta_pkg::S_DISPATCH: begin
                unique case (r_func)
                    tsta_pkg::FUNC_CLEAR: n_state = tsta_pkg::S_DONE;
                    tsta_pkg::FUNC_INSERT: begin
                        if (!ids_ok || new_end > cyc33) n_state = tsta_pkg::S_DONE;
                        else                            n_state = tsta_pkg::S_INS_INIT;
                    end
                    default: begin
                        if (r_func == tsta_pkg::FUNC_AUTO && !ids_ok)
                            n_state = tsta_pkg::S_DONE;
                        else if (len33 > cyc33)
                            n_state = tsta_pkg::S_DONE;
                        else if (r_count == '0)
                            n_state = (r_func == tsta_pkg::FUNC_AUTO) ?
                                      tsta_pkg::S_INS_INIT : tsta_pkg::S_DONE;
                        else
                            n_state = tsta_pkg::S_FIND_RD;
                    end
                endcase
            end
            tsta_pkg::S_FIND_RD: n_state = tsta_pkg::S_FIND_EV;
            tsta_pkg::S_FIND_EV: begin
                if (gap_ok)
                    n_state = (r_func == tsta_pkg::FUNC_AUTO) ?
                              tsta_pkg::S_INS_INIT : tsta_pkg::S_DONE;
                else if (last_entry) n_state = tsta_pkg::S_FIND_END;
                else                 n_state = tsta_pkg::S_FIND_RD;
            end
            tsta_pkg::S_FIND_END: begin
                if (end_ok && r_func == tsta_pkg::FUNC_AUTO) n_state = tsta_pkg::S_INS_INIT;
                else                                         n_state = tsta_pkg::S_DONE;
            end
            tsta_pkg::S_INS_INIT: begin
                n_state = (r_count == '0) ? tsta_pkg::S_INS_DEC : tsta_pkg::S_INS_RD;
            end
            tsta_pkg::S_INS_RD: n_state = tsta_pkg::S_INS_EV;
            tsta_pkg::S_INS_EV: begin
                if (!(start33 >= ent_end || new_end <= {1'b0, rd_ent.slot_start}))
                    n_state = tsta_pkg::S_DONE;
                else if (last_entry) n_state = tsta_pkg::S_INS_DEC;
                else                 n_state = tsta_pkg::S_INS_RD;
            end
            tsta_pkg::S_INS_DEC: begin
                if (r_count >= CW'(TABLE_DEPTH)) n_state = tsta_pkg::S_DONE;
                else if (r_count == r_pos)       n_state = tsta_pkg::S_INS_WR;
                else                             n_state = tsta_pkg::S_SHF_RD;
            end
            tsta_pkg::S_SHF_RD: n_state = tsta_pkg::S_SHF_WR;
            tsta_pkg::S_SHF_WR: begin
                n_state = (r_idx == r_pos) ? tsta_pkg::S_INS_WR : tsta_pkg::S_SHF_RD;
            end
            tsta_pkg::S_INS_WR: n_state = tsta_pkg::S_DONE;
            tsta_pkg::S_DONE: begin
                if (!r_out_valid || m_axis_tready) n_state = tsta_pkg::S_IDLE;
            end
            default: n_state = tsta_pkg::S_IDLE;
        endcase
    end

    // datapath updates
    always_comb begin
        n_count    = r_count;
        n_idx      = r_idx;
        n_pos      = r_pos;
        n_prev_end = r_prev_end;
        n_start    = r_start;
        n_status   = r_status;
        n_win      = r_win;
        unique case (r_state)
            tsta_pkg::S_DISPATCH: begin
                n_status   = tsta_pkg::ST_OK;
                n_win      = '0;
                n_idx      = '0;
                n_prev_end = '0;
                unique case (r_func)
                    tsta_pkg::FUNC_CLEAR: n_count = '0;
                    tsta_pkg::FUNC_INSERT: begin
                        if (!ids_ok)              n_status = tsta_pkg::ST_BAD_ID;
                        else if (new_end > cyc33) n_status = tsta_pkg::ST_CONFLICT;
                    end
                    default: begin
                        if (r_func == tsta_pkg::FUNC_AUTO && !ids_ok)
                            n_status = tsta_pkg::ST_BAD_ID;
                        else if (len33 > cyc33)
                            n_status = tsta_pkg::ST_NO_WINDOW;
                        else if (r_count == '0) begin
                            // empty table: window opens at the lower bound
                            n_start = r_after;
                            if (r_func == tsta_pkg::FUNC_FIND) n_win = r_after;
                        end
                    end
                endcase
            end
            tsta_pkg::S_FIND_EV: begin
                if (gap_ok) begin
                    n_start = 32'(tsta_pkg::gap_lo(r_prev_end, {1'b0, r_after}));
                    if (r_func == tsta_pkg::FUNC_FIND) n_win = n_start;
                end else begin
                    n_prev_end = ent_end;
                    n_idx      = CW'(r_idx + CW'(1));
                end
            end
            tsta_pkg::S_FIND_END: begin
                if (end_ok) begin
                    n_start = 32'(tsta_pkg::gap_lo(r_prev_end, {1'b0, r_after}));
                    if (r_func == tsta_pkg::FUNC_FIND) n_win = n_start;
                end else begin
                    n_status = tsta_pkg::ST_NO_WINDOW;
                end
            end
            tsta_pkg::S_INS_INIT: begin
                n_idx = '0;
                n_pos = '0;
            end
            tsta_pkg::S_INS_EV: begin
                if (!(start33 >= ent_end || new_end <= {1'b0, rd_ent.slot_start}))
                    n_status = tsta_pkg::ST_CONFLICT;
                if (rd_ent.slot_start <= r_start) n_pos = CW'(r_idx + CW'(1));
                n_idx = CW'(r_idx + CW'(1));
            end
            tsta_pkg::S_INS_DEC: begin
                if (r_count >= CW'(TABLE_DEPTH)) n_status = tsta_pkg::ST_FULL;
                n_idx = CW'(r_count - CW'(1));
            end
            tsta_pkg::S_SHF_WR: begin
                if (r_idx != r_pos) n_idx = CW'(r_idx - CW'(1));
            end
            tsta_pkg::S_INS_WR: begin
                n_count = CW'(r_count + CW'(1));
                n_win   = r_start;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tsta_pkg::S_IDLE;
            r_cycle     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) r_cycle <= i_cfg_wdata;
            if (r_state == tsta_pkg::S_DONE && (!r_out_valid || m_axis_tready))
                r_out_valid <= 1'b1;
            else if (m_axis_tready)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_pos      <= n_pos;
        r_prev_end <= n_prev_end;
        r_status   <= n_status;
        r_win      <= n_win;
        if (accept) begin
            r_func      <= s_axis_tuser;
            r_comp_id   <= s_axis_tdata[15:0];
            r_func_id   <= s_axis_tdata[31:16];
            r_arg       <= s_axis_tdata[47:32];
            r_start     <= s_axis_tdata[79:48];
            r_len       <= s_axis_tdata[111:80];
            r_div       <= s_axis_tdata[207:176];
            r_off       <= s_axis_tdata[239:208];
            // auto allocate searches the whole cycle and marks the entry complete
            if (s_axis_tuser == tsta_pkg::FUNC_AUTO) begin
                r_after     <= '0;
                r_before    <= r_cycle;
                r_done_flag <= 1'b1;
            end else begin
                r_after     <= s_axis_tdata[143:112];
                r_before    <= s_axis_tdata[175:144];
                r_done_flag <= s_axis_tdata[240];
            end
        end else begin
            r_start <= n_start;
        end
        if (r_state == tsta_pkg::S_DONE && (!r_out_valid || m_axis_tready))
            r_out_data <= {7'd0, 6'(r_count), r_win, r_status};
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

>>> rtl/tsta_checker.sv
// Port-level assertions for the time slot table allocator, bound to the top level.
module tsta_checker #(
    parameter int TABLE_DEPTH = 32
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    // held result beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= tsta_pkg::ST_FULL)
        else $error("status code out of range");

    a_fail_zero_win: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] != tsta_pkg::ST_OK |-> m_axis_tdata[34:3] == 32'd0)
        else $error("window start not zero on failure");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an operation is in progress");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && TABLE_DEPTH < 64 |-> m_axis_tdata[40:35] <= 6'(TABLE_DEPTH))
        else $error("entry count above table depth");

endmodule

bind time_slot_table_allocator_top tsta_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_tsta_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
